// ===== design/central_difference_gradient_unit_macros.svh =====
// assertion macros for the central difference gradient unit
`ifndef CENTRAL_DIFFERENCE_GRADIENT_UNIT_MACROS_SVH
`define CENTRAL_DIFFERENCE_GRADIENT_UNIT_MACROS_SVH

// same-cycle implication
`define CDG_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define CDG_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== design/cdg_pkg.sv =====
`timescale 1ns / 1ps
// shared constants, types and helpers of the gradient unit
package cdg_pkg;

	localparam int unsigned GRID_SIZE   = 64;
	localparam int unsigned DATA_W      = 24;
	localparam int unsigned POS_W       = 6;
	localparam int unsigned IDX_W       = $clog2(GRID_SIZE);
	localparam int unsigned QUEUE_DEPTH = 4;

	// result slots that one queued job can expand into, in emission order
	localparam int unsigned NUM_SLOTS   = 2;
	localparam int unsigned SLOT_GRAD   = 0;
	localparam int unsigned SLOT_LAST   = 1;

	typedef logic signed [DATA_W-1:0] data_t;
	typedef logic [POS_W-1:0]         pos_t;
	typedef logic [IDX_W-1:0]         idx_t;
	typedef logic [NUM_SLOTS-1:0]     slot_mask_t;

	localparam idx_t IDX_LAST = idx_t'(GRID_SIZE - 1);

	typedef struct packed {
		data_t      grad_x;
		data_t      grad_y;
		pos_t       row_a;
		pos_t       row_b;
		pos_t       col;
		slot_mask_t slots;
		logic       done;
	} job_t;

	function automatic pos_t to_pos(idx_t v);
		logic [IDX_W+POS_W-1:0] wide;
		wide = {{POS_W{1'b0}}, v};
		return wide[POS_W-1:0];
	endfunction

	localparam pos_t POS_LAST = to_pos(IDX_LAST);

endpackage

// ===== design/cdg_in_if.sv =====
`timescale 1ns / 1ps
// sample channel of the gradient unit
interface cdg_in_if;
	import cdg_pkg::*;

	logic  valid;
	logic  ready;
	data_t potential;

	modport source (output valid, output potential, input ready);
	modport sink (input valid, input potential, output ready);

endinterface

// ===== design/cdg_out_if.sv =====
`timescale 1ns / 1ps
// result channel of the gradient unit
interface cdg_out_if;
	import cdg_pkg::*;

	logic  valid;
	logic  ready;
	data_t grad_x;
	data_t grad_y;
	pos_t  row_index;
	pos_t  col_index;
	logic  grid_done;

	modport source (output valid, output grad_x, output grad_y, output row_index,
		output col_index, output grid_done, input ready);
	modport sink (input valid, input grad_x, input grad_y, input row_index,
		input col_index, input grid_done, output ready);

endinterface

// ===== design/central_difference_gradient_unit.sv =====
`timescale 1ns / 1ps
// top level of the central difference gradient unit
//
//  channel   dir  transaction
//  samples   in   potential (signed Q8.16), raster order, row by row
//  results   out  grad_x, grad_y, row_index, col_index, grid_done
//
//  one sample per cycle is taken while the job queue has room
//  a sample passes stages s1 and s2, then its job is pushed; the back end registers its results
//  one result leaves per cycle if ready; a last-row sample yields two, a second-row sample none
//  on the last row the queue fills and intake slows to the result rate
//  the result stage owns one output register, so the back end stalls on its own
//  reset clears the raster counters, pipeline valids, queue and output valid
module central_difference_gradient_unit (
	input  logic      clk,
	input  logic      arst_n,
	cdg_in_if.sink    samples,
	cdg_out_if.source results
);
	import cdg_pkg::*;

	job_t job_push;
	job_t job_head;
	logic push;
	logic full;
	logic pop;
	logic head_valid;

	cdg_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.samples    (samples),
		.queue_full (full),
		.push       (push),
		.job        (job_push)
	);

	cdg_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.job_in     (job_push),
		.full       (full),
		.pop        (pop),
		.head       (job_head),
		.head_valid (head_valid)
	);

	cdg_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head       (job_head),
		.head_valid (head_valid),
		.pop        (pop),
		.results    (results)
	);

endmodule

// ===== design/cdg_ram.sv =====
`timescale 1ns / 1ps
// generic single-port-write ram with registered read-first output
module cdg_ram #(
	parameter int unsigned WIDTH = 24,
	parameter int unsigned DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// ===== design/cdg_front.sv =====
`timescale 1ns / 1ps
// front end: sample intake, line buffers, stencil arithmetic and job build
module cdg_front (
	input  logic          clk,
	input  logic          arst_n,
	cdg_in_if.sink        samples,
	input  logic          queue_full,
	output logic          push,
	output cdg_pkg::job_t job
);
	import cdg_pkg::*;

	logic  adv;
	logic  accept;
	idx_t  row_q;
	idx_t  col_q;
	idx_t  col_ahead;

	logic  valid_s1;
	data_t sample_s1;
	idx_t  row_s1;
	idx_t  col_s1;

	logic  valid_s2;
	data_t sample_s2;
	data_t right_s2;
	data_t left_s2;
	idx_t  row_s2;
	idx_t  col_s2;

	data_t line_a_rd;
	data_t line_b_rd;

	data_t above_q;
	data_t left_q;

	logic  interior;
	idx_t  row_prev;

	function automatic data_t half_diff(data_t a, data_t b);
		logic signed [DATA_W:0] d;
		d = {a[DATA_W-1], a} - {b[DATA_W-1], b};
		return d[DATA_W:1];
	endfunction

	assign adv           = !queue_full;
	assign samples.ready = adv;
	assign accept        = samples.valid && adv;
	assign col_ahead     = (col_q == IDX_LAST) ? '0 : col_q + idx_t'(1);

	// raster position of the next sample
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_q <= '0;
			col_q <= '0;
		end else if (accept) begin
			if (col_q == IDX_LAST) begin
				col_q <= '0;
				row_q <= (row_q == IDX_LAST) ? '0 : row_q + idx_t'(1);
			end else begin
				col_q <= col_q + idx_t'(1);
			end
		end
	end

	// one row back, read one column ahead
	cdg_ram #(.WIDTH(DATA_W), .DEPTH(GRID_SIZE)) u_line_a (
		.clk   (clk),
		.we    (accept),
		.waddr (col_q),
		.wdata (samples.potential),
		.re    (accept),
		.raddr (col_ahead),
		.rdata (line_a_rd)
	);

	// two rows back
	cdg_ram #(.WIDTH(DATA_W), .DEPTH(GRID_SIZE)) u_line_b (
		.clk   (clk),
		.we    (adv && valid_s1),
		.waddr (col_s1),
		.wdata (above_q),
		.re    (adv && valid_s1),
		.raddr (col_s1),
		.rdata (line_b_rd)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else if (adv) begin
			valid_s1 <= accept;
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			sample_s1 <= samples.potential;
			row_s1    <= row_q;
			col_s1    <= col_q;
		end
		if (adv && valid_s1) begin
			sample_s2 <= sample_s1;
			right_s2  <= line_a_rd;
			left_s2   <= left_q;
			row_s2    <= row_s1;
			col_s2    <= col_s1;
			above_q   <= line_a_rd;
			left_q    <= above_q;
		end
	end

	// each sample finishes the point above it
	always_comb begin
		row_prev = (row_s2 == '0) ? '0 : row_s2 - idx_t'(1);
		interior = (row_s2 > idx_t'(1)) && (col_s2 != '0) && (col_s2 != IDX_LAST);

		push = adv && valid_s2 && (row_s2 != idx_t'(1));

		job.grad_x = interior ? half_diff(line_b_rd, sample_s2) : '0;
		job.grad_y = interior ? half_diff(left_s2, right_s2) : '0;
		job.row_a  = to_pos(row_prev);
		job.row_b  = to_pos(row_s2);
		job.col    = to_pos(col_s2);

		job.slots            = '0;
		job.slots[SLOT_GRAD] = 1'b1;
		job.slots[SLOT_LAST] = (row_s2 == IDX_LAST);
		job.done             = (row_s2 == IDX_LAST) && (col_s2 == IDX_LAST);
	end

endmodule

// ===== design/cdg_queue.sv =====
`timescale 1ns / 1ps
// short job queue between front and back ends
module cdg_queue (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  cdg_pkg::job_t job_in,
	output logic          full,
	input  logic          pop,
	output cdg_pkg::job_t head,
	output logic          head_valid
);
	import cdg_pkg::*;

	localparam int unsigned PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);
	localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);
	localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(QUEUE_DEPTH);

	job_t             entries_q [QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_push;
	logic             do_pop;

	assign full       = (count_q == CNT_FULL);
	assign head_valid = (count_q != '0);
	assign head       = entries_q[rd_ptr_q];
	assign do_push    = push && !full;
	assign do_pop     = pop && head_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + PTR_W'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_LAST) ? '0 : rd_ptr_q + PTR_W'(1);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + CNT_W'(1);
			end else if (do_pop && !do_push) begin
				count_q <= count_q - CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			entries_q[wr_ptr_q] <= job_in;
		end
	end

endmodule

// ===== design/cdg_back.sv =====
`timescale 1ns / 1ps
// back end: expands queued jobs into result transactions
module cdg_back (
	input  logic          clk,
	input  logic          arst_n,
	input  cdg_pkg::job_t head,
	input  logic          head_valid,
	output logic          pop,
	cdg_out_if.source     results
);
	import cdg_pkg::*;

	slot_mask_t sent_q;
	slot_mask_t pend;
	slot_mask_t pick;
	slot_mask_t left;
	logic       load;

	logic       out_valid_q;
	data_t      grad_x_q;
	data_t      grad_y_q;
	pos_t       row_q;
	pos_t       col_q;
	logic       done_q;

	assign pend = head.slots & ~sent_q;
	assign pick = pend & (~pend + slot_mask_t'(1));
	assign left = pend & ~pick;
	assign load = head_valid && (!out_valid_q || results.ready);
	assign pop  = load && (left == '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sent_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (load) begin
				sent_q      <= (left == '0) ? '0 : (sent_q | pick);
				out_valid_q <= 1'b1;
			end else if (results.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			if (pick[SLOT_GRAD]) begin
				grad_x_q <= head.grad_x;
				grad_y_q <= head.grad_y;
				row_q    <= head.row_a;
				col_q    <= head.col;
				done_q   <= 1'b0;
			end else begin
				grad_x_q <= '0;
				grad_y_q <= '0;
				row_q    <= head.row_b;
				col_q    <= head.col;
				done_q   <= head.done;
			end
		end
	end

	assign results.valid     = out_valid_q;
	assign results.grad_x    = grad_x_q;
	assign results.grad_y    = grad_y_q;
	assign results.row_index = row_q;
	assign results.col_index = col_q;
	assign results.grid_done = done_q;

endmodule

// ===== design/cdg_checker.sv =====
`timescale 1ns / 1ps
// port-level checks of the gradient unit and their bind
`include "central_difference_gradient_unit_macros.svh"

module cdg_checker (
	input logic           clk,
	input logic           arst_n,
	input logic           out_valid,
	input logic           out_ready,
	input cdg_pkg::data_t grad_x,
	input cdg_pkg::data_t grad_y,
	input cdg_pkg::pos_t  row_index,
	input cdg_pkg::pos_t  col_index,
	input logic           grid_done
);
	import cdg_pkg::*;

	logic on_border;

	assign on_border = (GRID_SIZE <= 64) && ((row_index == '0) || (col_index == '0) ||
		(row_index == POS_LAST) || (col_index == POS_LAST));

	`CDG_ASSERT_NOW(a_done_at_corner, clk, arst_n, out_valid && grid_done,
		(row_index == POS_LAST) && (col_index == POS_LAST), "grid end flag off the last point")

	`CDG_ASSERT_NOW(a_border_zero, clk, arst_n, out_valid && on_border,
		(grad_x == '0) && (grad_y == '0), "non-zero gradient on the border")

	`CDG_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && !out_ready,
		out_valid && $stable(grad_x) && $stable(grad_y) && $stable(row_index) &&
		$stable(col_index) && $stable(grid_done), "stalled result changed")

	`CDG_ASSERT_NEXT(a_single_done, clk, arst_n, out_valid && out_ready && grid_done,
		!(out_valid && grid_done), "grid end flag repeated")

endmodule

bind central_difference_gradient_unit cdg_checker u_cdg_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.out_valid (results.valid),
	.out_ready (results.ready),
	.grad_x    (results.grad_x),
	.grad_y    (results.grad_y),
	.row_index (results.row_index),
	.col_index (results.col_index),
	.grid_done (results.grid_done)
);
